[rtl/core/cstp_pkg.sv]
`default_nettype none

package cstp_pkg;

  localparam int SITES_DEF = 64;

  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NO_PEND = 2'd3
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] site_id;
    logic [63:0] stamp;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  site_slot;
    logic [15:0] pending_depth;
    logic [63:0] site_total_time;
    logic [31:0] site_call_count;
    logic [31:0] site_nested_count;
    logic [15:0] open_regions;
    logic [63:0] profiled_total;
    logic [63:0] call_total;
  } out_item_t;

  // one site's counters as held in the entry memory
  typedef struct packed {
    logic [15:0] pending;
    logic [63:0] start_stamp;
    logic [63:0] acc_time;
    logic [31:0] calls;
    logic [31:0] nested;
  } entry_t;

  // lookup stage to update stage
  typedef struct packed {
    logic        alloc;
    status_t     status;
    logic        mode;
    logic [63:0] stamp;
  } look_t;

endpackage

`default_nettype wire

[rtl/core/cstp_lookup.sv]
`default_nettype none

module cstp_lookup #(
  parameter int  SITES = cstp_pkg::SITES_DEF,
  localparam int SLOT_W = $clog2(SITES),
  localparam int USED_W = $clog2(SITES + 1)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     advance,
  input  wire                     in_valid,
  input  cstp_pkg::in_item_t      in_item,
  output logic                    look_valid,
  output cstp_pkg::look_t         look,
  output logic [SLOT_W-1:0]       slot,
  output logic [USED_W-1:0]       used
);

  logic                  a_valid_r;
  cstp_pkg::in_item_t    a_item_r;
  logic [31:0]           key_r [SITES];
  logic [USED_W-1:0]     used_r;
  logic [USED_W-1:0]     used_nxt;
  logic [SITES-1:0]      hit;
  logic [SLOT_W-1:0]     hit_slot;
  logic                  found;
  logic                  full;
  logic                  alloc;
  logic                  is_start;
  cstp_pkg::status_t     status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      a_item_r <= in_item;
    end
  end

  // parallel key match over the entries in use
  always_comb begin
    hit      = '0;
    hit_slot = '0;
    for (int i = 0; i < SITES; i++) begin
      hit[i] = (USED_W'(i) < used_r) && (key_r[i] == a_item_r.site_id);
      if (hit[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
  end

  assign found    = |hit;
  assign full     = (used_r == USED_W'(SITES));
  assign is_start = (a_item_r.mode == cstp_pkg::MODE_START);
  assign alloc    = a_valid_r && is_start && !found && !full;

  always_comb begin
    if (found) begin
      status = cstp_pkg::ST_OK;
    end else if (is_start) begin
      status = full ? cstp_pkg::ST_FULL : cstp_pkg::ST_OK;
    end else begin
      status = cstp_pkg::ST_UNKNOWN;
    end
  end

  always_comb begin
    if (found) begin
      slot = hit_slot;
    end else if (!full) begin
      slot = used_r[SLOT_W-1:0];
    end else begin
      slot = '0;
    end
  end

  assign used_nxt = used_r + USED_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (advance && alloc) begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && alloc) begin
      key_r[used_r[SLOT_W-1:0]] <= a_item_r.site_id;
    end
  end

  assign look_valid   = a_valid_r;
  assign look.alloc   = alloc;
  assign look.status  = status;
  assign look.mode    = a_item_r.mode;
  assign look.stamp   = a_item_r.stamp;
  assign used         = used_r;

endmodule

`default_nettype wire

[rtl/core/cstp_update.sv]
`default_nettype none

module cstp_update #(
  parameter int  SITES = cstp_pkg::SITES_DEF,
  localparam int SLOT_W = $clog2(SITES)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     advance,
  input  wire                     look_valid,
  input  cstp_pkg::look_t         look,
  input  wire  [SLOT_W-1:0]       slot,
  output logic                    out_valid,
  output cstp_pkg::out_item_t     out_item
);

  cstp_pkg::entry_t     mem [SITES];
  cstp_pkg::entry_t     q_r;
  cstp_pkg::entry_t     fwd_r;
  logic                 fwd_hit_r;
  logic                 b_valid_r;
  cstp_pkg::look_t      b_look_r;
  logic [SLOT_W-1:0]    b_slot_r;
  cstp_pkg::entry_t     cur;
  cstp_pkg::entry_t     wr_data;
  logic                 wr_en;
  cstp_pkg::status_t    res_status;
  logic [63:0]          elapsed;
  logic [15:0]          open_r;
  logic [15:0]          open_nxt;
  logic [63:0]          prof_r;
  logic [63:0]          prof_nxt;
  logic [63:0]          calls_r;
  logic [63:0]          calls_nxt;
  logic                 out_valid_r;
  cstp_pkg::out_item_t  out_item_r;
  cstp_pkg::out_item_t  out_item_nxt;
  logic                 site_err;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b_slot_r] <= wr_data;
    end
    if (advance) begin
      q_r <= mem[slot];
    end
  end

  // the read above sees the old word when the update stage writes the same slot
  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_hit_r <= wr_en && (b_slot_r == slot);
      fwd_r     <= wr_data;
      b_look_r  <= look;
      b_slot_r  <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= look_valid;
    end
  end

  // a freshly allocated entry starts from all zero
  always_comb begin
    if (b_look_r.alloc) begin
      cur = '0;
    end else if (fwd_hit_r) begin
      cur = fwd_r;
    end else begin
      cur = q_r;
    end
  end

  assign elapsed = b_look_r.stamp - cur.start_stamp;

  always_comb begin
    wr_data    = cur;
    res_status = b_look_r.status;
    open_nxt   = open_r;
    prof_nxt   = prof_r;
    calls_nxt  = calls_r;
    if (b_look_r.status == cstp_pkg::ST_OK) begin
      if (b_look_r.mode == cstp_pkg::MODE_START) begin
        if (cur.pending != cstp_pkg::DEPTH_MAX) begin
          wr_data.pending = cur.pending + 16'd1;
          if (open_r != cstp_pkg::DEPTH_MAX) begin
            open_nxt = open_r + 16'd1;
          end
          if (cur.pending == 16'd0) begin
            wr_data.start_stamp = b_look_r.stamp;
          end
        end
      end else if (cur.pending == 16'd0) begin
        res_status = cstp_pkg::ST_NO_PEND;
      end else begin
        if (open_r != 16'd0) begin
          open_nxt = open_r - 16'd1;
        end
        wr_data.pending = cur.pending - 16'd1;
        if (cur.pending == 16'd1) begin
          // outermost end closes the timed region
          wr_data.acc_time = cur.acc_time + elapsed;
          wr_data.calls    = cur.calls + 32'd1;
          calls_nxt        = calls_r + 64'd1;
          if (open_nxt == 16'd0) begin
            prof_nxt = prof_r + elapsed;
          end
        end else begin
          wr_data.nested = cur.nested + 32'd1;
        end
      end
    end
  end

  assign wr_en    = advance && b_valid_r && (res_status == cstp_pkg::ST_OK);
  assign site_err = (res_status == cstp_pkg::ST_FULL) || (res_status == cstp_pkg::ST_UNKNOWN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= '0;
      prof_r  <= '0;
      calls_r <= '0;
    end else if (advance && b_valid_r) begin
      open_r  <= open_nxt;
      prof_r  <= prof_nxt;
      calls_r <= calls_nxt;
    end
  end

  always_comb begin
    out_item_nxt.status            = res_status;
    out_item_nxt.site_slot         = site_err ? 6'd0 : 6'(b_slot_r);
    out_item_nxt.pending_depth     = site_err ? 16'd0 : wr_data.pending;
    out_item_nxt.site_total_time   = site_err ? 64'd0 : wr_data.acc_time;
    out_item_nxt.site_call_count   = site_err ? 32'd0 : wr_data.calls;
    out_item_nxt.site_nested_count = site_err ? 32'd0 : wr_data.nested;
    out_item_nxt.open_regions      = open_nxt;
    out_item_nxt.profiled_total    = prof_nxt;
    out_item_nxt.call_total        = calls_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/core/call_site_time_profiler.sv]
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_item   (mode, site_id, stamp)
// out       output     out_valid/out_stall out_item  (status, site and global counters)
//
// one event per clock sustained while out_stall holds nothing; a result passes these stages in order
// (input register with key match, registered entry memory read, update and result register)
// back-to-back events on the same site are forwarded around the memory read
// rst_n clears the pipeline valids, the fill count and the global sums; entries are
// zeroed as they are allocated, so no clearing pass runs after reset
// out_stall with a result waiting holds every stage and raises in_stall
`default_nettype none

module call_site_time_profiler #(
  parameter int  SITES = cstp_pkg::SITES_DEF,
  localparam int SLOT_W = $clog2(SITES),
  localparam int USED_W = $clog2(SITES + 1)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  cstp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cstp_pkg::out_item_t  out_item
);

  logic               advance;
  logic               look_valid;
  cstp_pkg::look_t    look;
  logic [SLOT_W-1:0]  slot;
  logic [USED_W-1:0]  used;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  cstp_lookup #(
    .SITES(SITES)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .look_valid (look_valid),
    .look       (look),
    .slot       (slot),
    .used       (used)
  );

  cstp_update #(
    .SITES(SITES)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .look_valid (look_valid),
    .look       (look),
    .slot       (slot),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= USED_W'(SITES))
    else $error("entry fill count beyond table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (used != $past(used)) |-> used == $past(used) + USED_W'(1))
    else $error("entry fill count moved by other than one");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == cstp_pkg::ST_FULL) |-> used == USED_W'(SITES))
    else $error("table full reported with free entries");

  a_no_pend_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == cstp_pkg::ST_NO_PEND) |-> out_item.pending_depth == 16'd0)
    else $error("end without pending start on a site with open depth");

endmodule

`default_nettype wire
